// ----- src/hdtl_pkg.sv -----
// Shared types and constants of the hex dump text loader.
package hdtl_pkg;

  localparam int ADDR_W = 16;
  localparam int EXT_W  = ADDR_W + 1;

  localparam logic [1:0] MODE_OFFSET = 2'd0;
  localparam logic [1:0] MODE_DATA   = 2'd1;
  localparam logic [1:0] MODE_SKIP   = 2'd2;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data;
    logic              status;
    logic [EXT_W-1:0]  extent;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

// ----- src/hex_dump_text_loader_unit.sv -----
// Top level of the hex dump text loader: input register, parser and result queue.
//
// Input channel in_*: one ASCII character of a text hex dump per item in
// in_tdata; an item with in_tlast high ends the dump (its character is
// ignored) and brings the final status.
// Result channel out_*: out_tuser is 0 for a byte write (address, data,
// running extent) and 1 for the final status (status, extent). out_tlast
// marks the last result caused by one input item.
// Throughput: one character per cycle while out_tready stays high. A character
// causes zero or one result, an end item one or two; the four-entry result queue
// absorbs the extra result so input keeps flowing at one item per cycle.
// Path: an accepted item waits in the input register, and the parser step
// then writes its results into the queue, which presents them on out_*.
// Reset: all line and address state returns to its start values and the
// queue empties; after an end item the parser clears itself the same way.
// Stall: when the receiver holds out_tready low the queue fills, the input
// register holds its item, and in_tready drops; nothing is lost.
module hex_dump_text_loader_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] address, [23:16] data, [24] status, [41:25] extent
  output logic [0:0]  out_tuser,  // [0] kind
  output logic        out_tlast
);

  logic            vld_r, vld_nxt;
  logic [7:0]      char_r;
  logic            end_r;
  logic            room;
  logic            step;
  hdtl_pkg::push_t push;
  hdtl_pkg::res_t  res;

  assign step      = vld_r && room;
  assign in_tready = !vld_r || room;
  assign vld_nxt   = (in_tvalid && in_tready) ? 1'b1 : (step ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
      end_r  <= in_tlast;
    end
  end

  hdtl_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .char_i (char_r),
    .end_i  (end_r),
    .push_o (push)
  );

  hdtl_out_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_res_o   (res)
  );

  assign out_tdata = {6'd0, res.extent, res.status, res.data, res.address};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ----- src/hdtl_parser.sv -----
// Line parser state and per-character step logic of the hex dump text loader.
module hdtl_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_i,
  input  logic [7:0]         char_i,
  input  logic               end_i,
  output hdtl_pkg::push_t    push_o
);

  logic [1:0]                  mode_r, mode_nxt;
  logic                        start_r, start_nxt;
  logic [hdtl_pkg::ADDR_W-1:0] off_r, off_nxt;
  logic [hdtl_pkg::ADDR_W-1:0] waddr_r, waddr_nxt;
  logic [1:0]                  tlen_r, tlen_nxt;
  logic [3:0]                  hi_r, hi_nxt;
  logic [3:0]                  lo_r, lo_nxt;
  logic                        cnt_r, cnt_nxt;
  logic [hdtl_pkg::EXT_W-1:0]  ext_r, ext_nxt;

  logic [4:0]                  hex;
  logic                        is_space;
  logic                        emit;
  logic [hdtl_pkg::EXT_W-1:0]  wr_end;
  logic [hdtl_pkg::EXT_W-1:0]  wr_ext;
  logic [hdtl_pkg::EXT_W-1:0]  ext_fin;
  hdtl_pkg::res_t              wr_res;
  hdtl_pkg::res_t              st_res;

  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  assign hex      = hex_dec(char_i);
  assign is_space = (char_i == hdtl_pkg::CHAR_SPACE) || (char_i inside {[8'h09:8'h0D]});
  assign wr_end   = {1'b0, waddr_r} + {{(hdtl_pkg::EXT_W-1){1'b0}}, 1'b1};
  assign wr_ext   = (wr_end > ext_r) ? wr_end : ext_r;

  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    off_nxt   = off_r;
    waddr_nxt = waddr_r;
    tlen_nxt  = tlen_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    cnt_nxt   = cnt_r;
    ext_nxt   = ext_r;
    emit      = 1'b0;

    if (end_i || char_i == hdtl_pkg::CHAR_LF) begin
      if (mode_r == hdtl_pkg::MODE_DATA) begin
        emit = (tlen_r == 2'd2);
        if (tlen_r != 2'd1) begin
          cnt_nxt = 1'b1;
        end
      end
      mode_nxt  = hdtl_pkg::MODE_OFFSET;
      start_nxt = 1'b1;
      off_nxt   = '0;
      tlen_nxt  = 2'd0;
    end else if (mode_r == hdtl_pkg::MODE_OFFSET) begin
      if (char_i == hdtl_pkg::CHAR_COLON) begin
        if (start_r) begin
          mode_nxt = hdtl_pkg::MODE_SKIP;
        end else begin
          mode_nxt  = hdtl_pkg::MODE_DATA;
          waddr_nxt = off_r;
          tlen_nxt  = 2'd0;
        end
      end else if (hex[4]) begin
        off_nxt = {off_r[hdtl_pkg::ADDR_W-5:0], hex[3:0]};
      end else begin
        mode_nxt = hdtl_pkg::MODE_SKIP;
      end
      start_nxt = 1'b0;
    end else if (mode_r == hdtl_pkg::MODE_DATA) begin
      if (is_space) begin
        if (tlen_r == 2'd2) begin
          emit = 1'b1;
        end else if (tlen_r == 2'd1) begin
          mode_nxt = hdtl_pkg::MODE_SKIP;
        end
        tlen_nxt = 2'd0;
      end else if (tlen_r != 2'd2 && hex[4]) begin
        if (tlen_r == 2'd0) begin
          hi_nxt = hex[3:0];
        end else begin
          lo_nxt = hex[3:0];
        end
        tlen_nxt = tlen_r + 2'd1;
      end else begin
        mode_nxt = hdtl_pkg::MODE_SKIP;
        tlen_nxt = 2'd0;
      end
      start_nxt = 1'b0;
    end else begin
      start_nxt = 1'b0;
    end

    if (emit) begin
      waddr_nxt = wr_end[hdtl_pkg::ADDR_W-1:0];
      ext_nxt   = wr_ext;
    end
    ext_fin = ext_nxt;

    wr_res.kind    = hdtl_pkg::KIND_WRITE;
    wr_res.address = waddr_r;
    wr_res.data    = {hi_r, lo_r};
    wr_res.status  = hdtl_pkg::STATUS_OK;
    wr_res.extent  = wr_ext;
    wr_res.last    = !end_i;

    st_res.kind    = hdtl_pkg::KIND_STATUS;
    st_res.address = '0;
    st_res.data    = 8'd0;
    st_res.status  = (!cnt_nxt || ext_fin == '0) ? hdtl_pkg::STATUS_BAD : hdtl_pkg::STATUS_OK;
    st_res.extent  = ext_fin;
    st_res.last    = 1'b1;

    push_o.res0 = wr_res;
    push_o.res1 = st_res;
    push_o.num  = 2'd0;
    if (step_i) begin
      if (end_i) begin
        if (emit) begin
          push_o.num = 2'd2;
        end else begin
          push_o.num  = 2'd1;
          push_o.res0 = st_res;
        end
      end else if (emit) begin
        push_o.num = 2'd1;
      end
    end

    if (end_i) begin
      mode_nxt  = hdtl_pkg::MODE_OFFSET;
      start_nxt = 1'b1;
      off_nxt   = '0;
      waddr_nxt = '0;
      tlen_nxt  = 2'd0;
      hi_nxt    = 4'd0;
      lo_nxt    = 4'd0;
      cnt_nxt   = 1'b0;
      ext_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= hdtl_pkg::MODE_OFFSET;
      start_r <= 1'b1;
      off_r   <= '0;
      waddr_r <= '0;
      tlen_r  <= 2'd0;
      hi_r    <= 4'd0;
      lo_r    <= 4'd0;
      cnt_r   <= 1'b0;
      ext_r   <= '0;
    end else if (step_i) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      off_r   <= off_nxt;
      waddr_r <= waddr_nxt;
      tlen_r  <= tlen_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
      cnt_r   <= cnt_nxt;
      ext_r   <= ext_nxt;
    end
  end

endmodule

// ----- src/hdtl_out_fifo.sv -----
// Four-entry result queue of the hex dump text loader, up to two pushes and one pop per cycle.
module hdtl_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  hdtl_pkg::push_t push_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hdtl_pkg::res_t  out_res_o
);

  hdtl_pkg::res_t mem [4];
  logic [1:0]     wptr_r, wptr_nxt;
  logic [1:0]     rptr_r, rptr_nxt;
  logic [2:0]     count_r, count_nxt;
  logic           pop;

  assign out_valid_o = (count_r != 3'd0);
  assign out_res_o   = mem[rptr_r];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (count_r <= 3'd2);

  always_comb begin
    wptr_nxt  = wptr_r + push_i.num;
    rptr_nxt  = rptr_r + {1'b0, pop};
    count_nxt = count_r + {1'b0, push_i.num} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push_i.num != 2'd0) begin
      mem[wptr_r] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem[wptr_r + 2'd1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 2'd0;
      rptr_r  <= 2'd0;
      count_r <= 3'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- dv/tb_hex_dump_text_loader_unit.sv -----
// Self-checking hex dump text loader testbench: fixed and random dumps against a line parser model.
module tb_hex_dump_text_loader_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import hdtl_pkg::*;

  localparam int LIMIT      = 600000;
  localparam int HOLD_LEN   = 250;
  localparam int STIM_ITEMS = 1450;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         hold_back;
  } stim_item_t;

  typedef enum {
    LN_GOOD, LN_HEADER, LN_COLON_FIRST, LN_NO_COLON, LN_BAD_OFFSET,
    LN_SHORT_TOKEN, LN_LONG_TOKEN, LN_BAD_CHAR, LN_NOISE
  } line_shape_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  stim_item_t char_stream[$];
  res_t       pending_results[$];
  stim_item_t tx_item;
  res_t       want;

  logic [1:0]  pm_mode;
  bit          pm_line_start;
  logic [15:0] pm_offset;
  logic [15:0] pm_waddr;
  logic [1:0]  pm_toklen;
  logic [3:0]  pm_hi;
  logic [3:0]  pm_lo;
  bit          pm_counted;
  logic [16:0] pm_extent;

  int chars_in, n_writes, n_status, n_errors, cycles, total;
  int tx_wait, tx_calm, rx_wait, rx_calm, rx_hold, hold_stage;

  hex_dump_text_loader_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    logic [7:0] d;
    if (c >= "0" && c <= "9") begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= "A" && c <= "F") begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    if (c >= "a" && c <= "f") begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CHAR_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic clear_parser();
    pm_mode = MODE_OFFSET;
    pm_line_start = 1'b1;
    pm_offset = '0;
    pm_waddr = '0;
    pm_toklen = '0;
    pm_hi = '0;
    pm_lo = '0;
    pm_counted = 1'b0;
    pm_extent = '0;
  endtask

  task automatic emit_byte();
    logic [16:0] nxt;
    res_t r;
    nxt = {1'b0, pm_waddr} + 17'd1;
    if (nxt > pm_extent) pm_extent = nxt;
    r = '0;
    r.kind = KIND_WRITE;
    r.address = pm_waddr;
    r.data = {pm_hi, pm_lo};
    r.status = STATUS_OK;
    r.extent = pm_extent;
    pending_results.push_back(r);
    pm_waddr = pm_waddr + 16'd1;
  endtask

  task automatic close_line();
    if (pm_mode == MODE_DATA) begin
      if (pm_toklen == 2'd2) emit_byte();
      if (pm_toklen != 2'd1) pm_counted = 1'b1;
    end
    pm_mode = MODE_OFFSET;
    pm_line_start = 1'b1;
    pm_offset = '0;
    pm_toklen = '0;
  endtask

  task automatic parse_item(logic [7:0] ch, logic eoi);
    int n0;
    logic [4:0] hv;
    res_t r;
    n0 = pending_results.size();
    hv = hex_nibble(ch);
    if (eoi) begin
      close_line();
      r = '0;
      r.kind = KIND_STATUS;
      r.status = (!pm_counted || pm_extent == '0) ? STATUS_BAD : STATUS_OK;
      r.extent = pm_extent;
      pending_results.push_back(r);
      clear_parser();
    end else if (ch == CHAR_LF) begin
      close_line();
    end else if (pm_mode == MODE_OFFSET) begin
      if (ch == CHAR_COLON) begin
        if (pm_line_start) begin
          pm_mode = MODE_SKIP;
        end else begin
          pm_mode = MODE_DATA;
          pm_waddr = pm_offset;
          pm_toklen = '0;
        end
      end else if (hv[4]) begin
        pm_offset = {pm_offset[11:0], hv[3:0]};
      end else begin
        pm_mode = MODE_SKIP;
      end
      pm_line_start = 1'b0;
    end else if (pm_mode == MODE_DATA) begin
      if (is_blank(ch)) begin
        if (pm_toklen == 2'd2) emit_byte();
        else if (pm_toklen == 2'd1) pm_mode = MODE_SKIP;
        pm_toklen = '0;
      end else if (pm_toklen < 2'd2 && hv[4]) begin
        if (pm_toklen == 2'd0) pm_hi = hv[3:0];
        else pm_lo = hv[3:0];
        pm_toklen = pm_toklen + 2'd1;
      end else begin
        pm_mode = MODE_SKIP;
        pm_toklen = '0;
      end
      pm_line_start = 1'b0;
    end else begin
      pm_line_start = 1'b0;
    end
    if (pending_results.size() > n0) pending_results[pending_results.size() - 1].last = 1'b1;
  endtask

  function automatic int idle_len(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put_ch(logic [7:0] c);
    char_stream.push_back('{ch: c, eoi: 1'b0, hold_back: 1'b0});
  endtask

  task automatic put_end();
    char_stream.push_back('{ch: 8'($urandom), eoi: 1'b1, hold_back: 1'b0});
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    if ($urandom_range(0, 1)) return 8'h37 + v;
    return 8'h57 + v;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 7))
      0: return CH_TAB;
      1: return CH_CR;
      2: return CH_VT;
      3: return CH_FF;
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) != 5'd0 || is_blank(c));
    return c;
  endfunction

  task automatic put_blanks(int n);
    repeat (n) put_ch(blank_char());
  endtask

  task automatic put_bad_token(line_shape_e shape);
    case (shape)
      LN_SHORT_TOKEN: put_ch(hex_char(4'($urandom)));
      LN_LONG_TOKEN: repeat ($urandom_range(3, 4)) put_ch(hex_char(4'($urandom)));
      default: begin
        case ($urandom_range(0, 2))
          0: begin
            put_ch(hex_char(4'($urandom)));
            put_ch(junk_char());
          end
          1: begin
            put_ch(junk_char());
            put_ch(hex_char(4'($urandom)));
          end
          default: put_ch(junk_char());
        endcase
      end
    endcase
  endtask

  task automatic put_line(line_shape_e shape, bit close);
    int ndig, ntok, bad_tok, bad_dig;
    logic [15:0] base;
    logic [7:0] c;
    ndig = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 4);
    base = ($urandom_range(0, 5) == 0) ? 16'hFFFF - 16'($urandom_range(0, 12)) : 16'($urandom);
    ntok = (shape == LN_HEADER) ? 0 : $urandom_range(1, 12);
    bad_tok = $urandom_range(0, (ntok > 0) ? ntok - 1 : 0);
    bad_dig = $urandom_range(0, ndig - 1);
    if (shape == LN_NOISE) begin
      repeat ($urandom_range(1, 12)) put_ch(8'($urandom_range(0, 255)));
    end else begin
      if (shape == LN_COLON_FIRST) put_ch(CHAR_COLON);
      for (int i = ndig - 1; i >= 0; i--) begin
        if (shape == LN_BAD_OFFSET && i == bad_dig) begin
          c = junk_char();
          put_ch((c == CHAR_COLON) ? blank_char() : c);
        end else begin
          put_ch(hex_char(i > 3 ? 4'($urandom) : base[4 * (i % 4) +: 4]));
        end
      end
      if (shape != LN_NO_COLON) put_ch(CHAR_COLON);
      put_blanks($urandom_range(0, 2));
      for (int t = 0; t < ntok; t++) begin
        if (t > 0) put_blanks($urandom_range(1, 2));
        if (t == bad_tok && shape inside {LN_SHORT_TOKEN, LN_LONG_TOKEN, LN_BAD_CHAR}) begin
          put_bad_token(shape);
        end else begin
          put_ch(hex_char(4'($urandom)));
          put_ch(hex_char(4'($urandom)));
        end
      end
      put_blanks($urandom_range(0, 1));
    end
    if (close) put_ch(CHAR_LF);
  endtask

  function automatic line_shape_e pick_shape();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return LN_GOOD;
    if (r < 62) return LN_HEADER;
    if (r < 67) return LN_COLON_FIRST;
    if (r < 72) return LN_NO_COLON;
    if (r < 78) return LN_BAD_OFFSET;
    if (r < 84) return LN_SHORT_TOKEN;
    if (r < 89) return LN_LONG_TOKEN;
    if (r < 94) return LN_BAD_CHAR;
    return LN_NOISE;
  endfunction

  task automatic put_dump(bit pause_first);
    int nlines, first;
    first = char_stream.size();
    nlines = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
    for (int i = 0; i < nlines; i++)
      put_line(pick_shape(), !(i == nlines - 1 && $urandom_range(0, 3) == 0));
    put_end();
    char_stream[first].hold_back = pause_first;
  endtask

  task automatic flag_error(string what);
    n_errors++;
    if (n_errors <= 10) $display("ERROR at %0t ns: %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v)
      flag_error($sformatf("%s expected 0x%0h got 0x%0h", name, exp_v, got_v));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_item(in_tdata, in_tlast);
        chars_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_tvalid <= 1'b0;
        end else if (char_stream.size() > 0 &&
                     !(char_stream[0].hold_back && pending_results.size() > 0)) begin
          tx_item = char_stream.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= tx_item.ch;
          in_tlast <= tx_item.eoi;
          tx_wait = idle_len(tx_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (hold_stage < 2 && chars_in >= ((hold_stage == 0) ? 300 : 1000)) begin
      hold_stage++;
      rx_hold = HOLD_LEN;
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_wait = idle_len(rx_calm);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result tdata 0x%0h tuser %0d", out_tdata, out_tuser));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, out_tuser[0]);
        check_field("address", want.address, out_tdata[15:0]);
        check_field("data", want.data, out_tdata[23:16]);
        check_field("status", want.status, out_tdata[24]);
        check_field("extent", want.extent, out_tdata[41:25]);
        check_field("tdata padding", '0, out_tdata[47:42]);
        check_field("last", want.last, out_tlast);
        if (want.kind == KIND_WRITE) n_writes++;
        else n_status++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d items sent, %0d results outstanding",
               cycles, chars_in, total, pending_results.size());
      $display("hex_dump_text_loader_unit regression: fail");
      $finish;
    end
  end

  initial begin
    clear_parser();
    put_end();
    put_text(":1\n");
    put_text("1\n");
    put_ch(CH_CR);
    put_text(":\n");
    put_ch(8'h00);
    put_ch(8'hFF);
    put_text(":\n");
    put_text("fFfF:aB\t0\n");
    put_text("2:\n");
    put_text("3:1:\n");
    put_text("10000:Cd");
    put_end();
    for (int d = 0; char_stream.size() < STIM_ITEMS; d++) put_dump(d % 5 == 0);
    total = char_stream.size();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (chars_in < total) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d characters and end marks; checked %0d byte writes and %0d dump statuses",
             total, n_writes, n_status);
    $display("lines covered: good, header only, bad offset, bad tokens, noise, unterminated");
    if (n_errors == 0) begin
      $display("hex_dump_text_loader_unit regression: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("hex_dump_text_loader_unit regression: fail");
    end
    $finish;
  end

endmodule
